// ===== sv/urb_pkg.sv =====
// Package for the UART register block: request kinds, interrupt sources, constants.
`default_nettype none
package urb_pkg;
  localparam int FifoDepth = 64;
  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = PtrW + 1;
  localparam logic [CntW-1:0] FifoFull = CntW'(FifoDepth);
  localparam logic [CntW-1:0] TxLimit = CntW'(FifoDepth - 16);

  localparam logic [2:0] REQ_WRITE = 3'd0;
  localparam logic [2:0] REQ_READ  = 3'd1;
  localparam logic [2:0] REQ_RXB   = 3'd2;
  localparam logic [2:0] REQ_PULL  = 3'd3;
  localparam logic [2:0] REQ_MODEM = 3'd4;

  localparam logic [2:0] SRC_MS   = 3'd0;
  localparam logic [2:0] SRC_TX   = 3'd1;
  localparam logic [2:0] SRC_RX   = 3'd2;
  localparam logic [2:0] SRC_RXF  = 3'd3;
  localparam logic [2:0] SRC_LS   = 3'd4;
  localparam logic [2:0] SRC_NONE = 3'd5;

  localparam logic [2:0] OFF_DATA = 3'd0;
  localparam logic [2:0] OFF_IER  = 3'd1;
  localparam logic [2:0] OFF_IIR  = 3'd2;
  localparam logic [2:0] OFF_LCR  = 3'd3;
  localparam logic [2:0] OFF_MCR  = 3'd4;
  localparam logic [2:0] OFF_LSR  = 3'd5;
  localparam logic [2:0] OFF_MSR  = 3'd6;
  localparam logic [2:0] OFF_SCR  = 3'd7;
endpackage
`default_nettype wire

// ===== sv/uart_register_block_top.sv =====
// UART register block top level: register file, rings, interrupt ranking.
//   channel | dir | handshake        | payload
//   in      | in  | in_valid/in_stall | req_type reg_offset write_data line_byte modem_lines
//   out     | out | out_valid/out_stall | read_data irq_level tx_valid tx_byte mc_valid ...
// One item per cycle unless the output stalls; items pass an input and an output register.
// The ring read port is a registered memory read, launched as the item is accepted.
// Synchronous reset clears all control and register state; rings hold no reset.
// Input stall is raised while an item waits in the input register behind a full,
// stalled output register.
`default_nettype none
module uart_register_block_top
  import urb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [2:0]  reg_offset,
  input  wire logic [7:0]  write_data,
  input  wire logic [7:0]  line_byte,
  input  wire logic [3:0]  modem_lines,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       read_data,
  output logic             irq_level,
  output logic             tx_valid,
  output logic [7:0]       tx_byte,
  output logic             mc_valid,
  output logic [3:0]       mc_lines,
  output logic [15:0]      divisor_value
);
  logic [7:0] rx_ring [FifoDepth];
  logic [7:0] tx_ring [FifoDepth];
  logic [PtrW-1:0] rx_head, tx_head, rx_head_next, tx_head_next;
  logic [CntW-1:0] rx_count, tx_count, rx_count_next, tx_count_next;
  logic [7:0] divisor_low, divisor_high, ier_shadow, line_control, scratch_value;
  logic [7:0] modem_status, modem_status_next;
  logic [7:0] divisor_low_next, divisor_high_next, ier_shadow_next;
  logic [7:0] line_control_next, scratch_value_next;
  logic [4:0] int_enable_mask, int_requested, mask_next, req_next;
  logic [2:0] int_active, active_next;
  logic [4:0] modem_control, modem_control_next;
  logic       irq_line, irq_next;

  // stage-1 registered item
  logic       s1_valid;
  logic [2:0] s1_type, s1_off;
  logic [7:0] s1_wd, s1_lb;
  logic [3:0] s1_ml;
  logic [7:0] rx_rd, tx_rd;

  logic s1_go;
  logic accept;
  assign s1_go    = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign accept   = in_valid && !in_stall;

  // Capture the item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept || s1_go) begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_type <= req_type;
      s1_off  <= reg_offset;
      s1_wd   <= write_data;
      s1_lb   <= line_byte;
      s1_ml   <= modem_lines;
    end
  end

  // Ring read heads: read at the head the state will have when the item runs
  logic [PtrW-1:0] rx_rd_addr, tx_rd_addr;
  assign rx_rd_addr = s1_go ? rx_head_next : rx_head;
  assign tx_rd_addr = s1_go ? tx_head_next : tx_head;

  logic rx_we, tx_we;
  logic [PtrW-1:0] rx_wa, tx_wa;
  logic [7:0] rx_wd, tx_wd;

  always_ff @(posedge clk) begin
    if (accept) begin
      rx_rd <= rx_ring[rx_rd_addr];
      tx_rd <= tx_ring[tx_rd_addr];
    end
    if (rx_we) rx_ring[rx_wa] <= rx_wd;
    if (tx_we) tx_ring[tx_wa] <= tx_wd;
  end

  // Bypass a write that lands on the slot just read
  logic rx_byp, tx_byp;
  logic [7:0] rx_byp_d, tx_byp_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_byp <= 1'b0;
      tx_byp <= 1'b0;
    end else if (accept) begin
      rx_byp <= rx_we && rx_wa == rx_rd_addr;
      tx_byp <= tx_we && tx_wa == tx_rd_addr;
    end
    if (accept) begin
      rx_byp_d <= rx_wd;
      tx_byp_d <= tx_wd;
    end
  end
  logic [7:0] rx_front, tx_front;
  assign rx_front = rx_byp ? rx_byp_d : rx_rd;
  assign tx_front = tx_byp ? tx_byp_d : tx_rd;

  function automatic logic [PtrW-1:0] slot(input logic [PtrW-1:0] h,
                                           input logic [CntW-1:0] c);
    logic [CntW:0] w;
    w = {1'b0, h} + {1'b0, c};
    if (w >= (CntW+1)'(FifoDepth)) w = w - (CntW+1)'(FifoDepth);
    return w[PtrW-1:0];
  endfunction

  // Item work
  logic [7:0] rd;
  logic txv, mcv;
  logic [7:0] txb;
  logic [3:0] mcl;
  logic dlab;
  logic [3:0] diff;
  logic [4:0] pend;

  always_comb begin
    rx_head_next = rx_head; rx_count_next = rx_count;
    tx_head_next = tx_head; tx_count_next = tx_count;
    divisor_low_next = divisor_low; divisor_high_next = divisor_high;
    ier_shadow_next = ier_shadow; line_control_next = line_control;
    scratch_value_next = scratch_value; modem_status_next = modem_status;
    modem_control_next = modem_control;
    mask_next = int_enable_mask; req_next = int_requested;
    active_next = int_active; irq_next = irq_line;
    rx_we = 1'b0; tx_we = 1'b0;
    rx_wa = slot(rx_head, rx_count); tx_wa = slot(tx_head, tx_count);
    rx_wd = s1_wd; tx_wd = s1_wd;
    rd = 8'd0; txv = 1'b0; txb = 8'd0; mcv = 1'b0; mcl = 4'd0;
    dlab = line_control[7];
    diff = modem_status[7:4] ^ s1_ml;
    begin : rank_blk
      logic rank;
      rank = 1'b0;
      case (s1_type)
        REQ_WRITE: begin
          case (s1_off)
            OFF_DATA: begin
              if (dlab) begin
                divisor_low_next = s1_wd;
              end else if (modem_control[4]) begin
                if (rx_count < FifoFull) begin
                  rx_we = 1'b1; rx_count_next = rx_count + 1'b1;
                  if (int_active != SRC_RX) begin
                    req_next[SRC_RX] = 1'b1; rank = 1'b1;
                  end
                end
              end else if (tx_count < FifoFull) begin
                tx_we = 1'b1; tx_count_next = tx_count + 1'b1;
                if (tx_count_next < TxLimit) begin
                  req_next[SRC_TX] = 1'b1; rank = 1'b1;
                end
              end
            end
            OFF_IER: begin
              if (dlab) begin
                divisor_high_next = s1_wd;
              end else begin
                mask_next = 5'd0;
                mask_next[SRC_RXF] = 1'b1;
                mask_next[SRC_RX] = s1_wd[0];
                mask_next[SRC_TX] = s1_wd[1];
                mask_next[SRC_LS] = s1_wd[2];
                mask_next[SRC_MS] = s1_wd[3];
                ier_shadow_next = s1_wd; rank = 1'b1;
              end
            end
            OFF_IIR: begin
              if (s1_wd[1]) begin rx_count_next = '0; rx_head_next = '0; end
              if (s1_wd[2]) begin tx_count_next = '0; tx_head_next = '0; end
            end
            OFF_LCR: line_control_next = s1_wd;
            OFF_MCR: begin
              modem_control_next = s1_wd[4:0]; mcv = 1'b1; mcl = s1_wd[3:0];
            end
            OFF_SCR: scratch_value_next = s1_wd;
            default: ;
          endcase
        end
        REQ_READ: begin
          case (s1_off)
            OFF_DATA: begin
              if (dlab) begin
                rd = divisor_low;
              end else if (rx_count != '0) begin
                rd = rx_front;
                rx_head_next = slot(rx_head, CntW'(1));
                rx_count_next = rx_count - 1'b1;
                req_next[SRC_RX] = (rx_count_next != '0);
                rank = 1'b1;
              end
            end
            OFF_IER: rd = dlab ? divisor_high : ier_shadow;
            OFF_IIR: begin
              active_next = SRC_NONE;
              case (int_active)
                SRC_MS: rd = 8'h00;
                SRC_TX: begin rd = 8'h02; req_next[SRC_TX] = 1'b0; rank = 1'b1; end
                SRC_RX: rd = 8'h04;
                SRC_RXF: begin rd = 8'h0c; req_next[SRC_RXF] = 1'b0; rank = 1'b1; end
                SRC_LS: rd = 8'h06;
                default: rd = 8'h01;
              endcase
            end
            OFF_LCR: rd = line_control;
            OFF_MCR: rd = {3'd0, modem_control};
            OFF_LSR: begin
              req_next[SRC_LS] = 1'b0; rank = 1'b1;
              rd = 8'h40;
              if (tx_count < FifoFull) rd = rd | 8'h20;
              if (rx_count != '0) rd = rd | 8'h01;
            end
            OFF_MSR: begin
              req_next[SRC_MS] = 1'b0; rank = 1'b1;
              rd = modem_status;
              modem_status_next = modem_status & 8'hf0;
            end
            default: rd = scratch_value;
          endcase
        end
        REQ_RXB: begin
          rx_wd = s1_lb;
          if (rx_count < FifoFull) begin
            rx_we = 1'b1; rx_count_next = rx_count + 1'b1;
            if (int_active != SRC_RX) begin
              req_next[SRC_RX] = 1'b1; rank = 1'b1;
            end
          end
        end
        REQ_PULL: begin
          if (tx_count != '0) begin
            txb = tx_front; txv = 1'b1;
            tx_head_next = slot(tx_head, CntW'(1));
            tx_count_next = tx_count - 1'b1;
          end
        end
        REQ_MODEM: begin
          if (diff != 4'd0) begin
            modem_status_next = {s1_ml, diff};
            req_next[SRC_MS] = 1'b1; rank = 1'b1;
          end
        end
        default: ;
      endcase
      // Rank pending sources, lowest index first
      pend = req_next & mask_next;
      if (rank) begin
        irq_next = |pend;
        if (pend[0]) active_next = SRC_MS;
        else if (pend[1]) active_next = SRC_TX;
        else if (pend[2]) active_next = SRC_RX;
        else if (pend[3]) active_next = SRC_RXF;
        else if (pend[4]) active_next = SRC_LS;
        else active_next = SRC_NONE;
      end
    end
    if (!s1_go) begin
      rx_we = 1'b0; tx_we = 1'b0;
    end
  end

  // Commit state and load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head <= '0; rx_count <= '0; tx_head <= '0; tx_count <= '0;
      divisor_low <= 8'd1; divisor_high <= 8'd0; ier_shadow <= 8'd0;
      int_enable_mask <= 5'b01000; int_requested <= 5'd0;
      int_active <= SRC_NONE; irq_line <= 1'b0;
      line_control <= 8'd0; modem_control <= 5'd0;
      scratch_value <= 8'd0; modem_status <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      if (s1_go) begin
        rx_head <= rx_head_next; rx_count <= rx_count_next;
        tx_head <= tx_head_next; tx_count <= tx_count_next;
        divisor_low <= divisor_low_next; divisor_high <= divisor_high_next;
        ier_shadow <= ier_shadow_next; int_enable_mask <= mask_next;
        int_requested <= req_next; int_active <= active_next;
        irq_line <= irq_next; line_control <= line_control_next;
        modem_control <= modem_control_next;
        scratch_value <= scratch_value_next; modem_status <= modem_status_next;
      end
      if (s1_go) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (s1_go) begin
      read_data <= rd; irq_level <= irq_next; tx_valid <= txv; tx_byte <= txb;
      mc_valid <= mcv; mc_lines <= mcl;
      divisor_value <= {divisor_high_next, divisor_low_next};
    end
  end

`ifndef SYNTHESIS
  a_rx_bound: assert property (@(posedge clk) disable iff (rst) rx_count <= FifoFull)
    else $error("rx count over depth");
  a_tx_bound: assert property (@(posedge clk) disable iff (rst) tx_count <= FifoFull)
    else $error("tx count over depth");
  a_irq_pend: assert property (@(posedge clk) disable iff (rst)
      irq_line == |(int_requested & int_enable_mask))
    else $error("irq line out of step with pending sources");
  a_tx_pull: assert property (@(posedge clk) disable iff (rst)
      s1_go && txv |-> tx_count != '0)
    else $error("pull from empty ring");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/uart_register_block_checker.sv =====
// Checker for the UART register block: watches both channels, predicts and compares results.
module uart_register_block_checker
  import urb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [2:0]  reg_offset,
  input  wire logic [7:0]  write_data,
  input  wire logic [7:0]  line_byte,
  input  wire logic [3:0]  modem_lines,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  read_data,
  input  wire logic        irq_level,
  input  wire logic        tx_valid,
  input  wire logic [7:0]  tx_byte,
  input  wire logic        mc_valid,
  input  wire logic [3:0]  mc_lines,
  input  wire logic [15:0] divisor_value,
  output int               fail_count,
  output int               pending_count,
  output int               result_count
);
  typedef struct packed {
    logic [7:0]  rd;
    logic        irq;
    logic        txv;
    logic [7:0]  txb;
    logic        mcv;
    logic [3:0]  mcl;
    logic [15:0] div;
  } uart_result_t;

  uart_result_t expected_results[$];

  // predicted register file state
  logic [7:0] rx_mem [FifoDepth];
  logic [7:0] tx_mem [FifoDepth];
  int rx_rd, rx_cnt, tx_rd, tx_cnt;
  logic [7:0] dll, dlm, ier_reg, lcr_reg, scr_reg, msr_reg;
  logic [4:0] enabled, requested, mcr_reg;
  logic [2:0] active_src;
  logic irq_now;

  function automatic void rerank();
    logic [4:0] pend;
    pend = requested & enabled;
    irq_now = 1'b0;
    active_src = SRC_NONE;
    for (int k = 4; k >= 0; k--) begin
      if (pend[k]) begin
        irq_now = 1'b1;
        active_src = 3'(k);
      end
    end
  endfunction

  function automatic void raise(logic [2:0] s);
    requested[s] = 1'b1;
    rerank();
  endfunction

  function automatic void withdraw(logic [2:0] s);
    requested[s] = 1'b0;
    rerank();
  endfunction

  function automatic void rx_add(logic [7:0] b);
    if (rx_cnt < FifoDepth) begin
      rx_mem[(rx_rd + rx_cnt) % FifoDepth] = b;
      rx_cnt++;
      if (active_src != SRC_RX) raise(SRC_RX);
    end
  endfunction

  function automatic void tx_add(logic [7:0] b);
    if (tx_cnt < FifoDepth) begin
      tx_mem[(tx_rd + tx_cnt) % FifoDepth] = b;
      tx_cnt++;
      if (tx_cnt < FifoDepth - 16) raise(SRC_TX);
    end
  endfunction

  function automatic logic [7:0] rx_take();
    logic [7:0] v;
    if (rx_cnt == 0) return 8'h00;
    v = rx_mem[rx_rd];
    rx_rd = (rx_rd + 1) % FifoDepth;
    rx_cnt--;
    if (rx_cnt == 0) withdraw(SRC_RX);
    else raise(SRC_RX);
    return v;
  endfunction

  function automatic logic [7:0] iir_read();
    case (active_src)
      SRC_MS: begin active_src = SRC_NONE; return 8'h00; end
      SRC_TX: begin withdraw(SRC_TX); return 8'h02; end
      SRC_RX: begin active_src = SRC_NONE; return 8'h04; end
      SRC_RXF: begin withdraw(SRC_RXF); return 8'h0c; end
      SRC_LS: begin active_src = SRC_NONE; return 8'h06; end
      default: begin active_src = SRC_NONE; return 8'h01; end
    endcase
  endfunction

  function automatic uart_result_t predict_access(logic [2:0] kind, logic [2:0] off,
                                                  logic [7:0] wv, logic [7:0] lb,
                                                  logic [3:0] ml);
    uart_result_t r;
    logic dlab;
    logic [3:0] diff;
    r = '0;
    dlab = lcr_reg[7];
    case (kind)
      REQ_WRITE: begin
        case (off)
          OFF_DATA: begin
            if (dlab) dll = wv;
            else if (mcr_reg[4]) rx_add(wv);
            else tx_add(wv);
          end
          OFF_IER: begin
            if (dlab) dlm = wv;
            else begin
              enabled = 5'b0;
              enabled[SRC_RXF] = 1'b1;
              enabled[SRC_RX] = wv[0];
              enabled[SRC_TX] = wv[1];
              enabled[SRC_LS] = wv[2];
              enabled[SRC_MS] = wv[3];
              ier_reg = wv;
              rerank();
            end
          end
          OFF_IIR: begin
            if (wv[1]) begin rx_cnt = 0; rx_rd = 0; end
            if (wv[2]) begin tx_cnt = 0; tx_rd = 0; end
          end
          OFF_LCR: lcr_reg = wv;
          OFF_MCR: begin
            mcr_reg = wv[4:0];
            r.mcv = 1'b1;
            r.mcl = wv[3:0];
          end
          OFF_SCR: scr_reg = wv;
          default: ;
        endcase
      end
      REQ_READ: begin
        case (off)
          OFF_DATA: r.rd = dlab ? dll : rx_take();
          OFF_IER: r.rd = dlab ? dlm : ier_reg;
          OFF_IIR: r.rd = iir_read();
          OFF_LCR: r.rd = lcr_reg;
          OFF_MCR: r.rd = {3'b0, mcr_reg};
          OFF_LSR: begin
            withdraw(SRC_LS);
            r.rd = 8'h40;
            if (tx_cnt < FifoDepth) r.rd[5] = 1'b1;
            if (rx_cnt != 0) r.rd[0] = 1'b1;
          end
          OFF_MSR: begin
            withdraw(SRC_MS);
            r.rd = msr_reg;
            msr_reg[3:0] = 4'h0;
          end
          default: r.rd = scr_reg;
        endcase
      end
      REQ_RXB: rx_add(lb);
      REQ_PULL: begin
        if (tx_cnt != 0) begin
          r.txb = tx_mem[tx_rd];
          r.txv = 1'b1;
          tx_rd = (tx_rd + 1) % FifoDepth;
          tx_cnt--;
        end
      end
      REQ_MODEM: begin
        diff = msr_reg[7:4] ^ ml;
        if (diff != 0) begin
          msr_reg = {ml, diff};
          raise(SRC_MS);
        end
      end
      default: ;
    endcase
    r.irq = irq_now;
    r.div = {dlm, dll};
    return r;
  endfunction

  assign pending_count = expected_results.size();

  // predict on input acceptance, compare on output acceptance
  always @(posedge clk) begin
    uart_result_t got, want;
    if (rst) begin
      rx_rd <= 0; rx_cnt <= 0; tx_rd <= 0; tx_cnt <= 0;
      dll <= 8'h01; dlm <= 8'h00; ier_reg <= 8'h00;
      enabled <= 5'b01000; requested <= 5'b0; active_src <= SRC_NONE; irq_now <= 1'b0;
      lcr_reg <= 8'h00; mcr_reg <= 5'h00; scr_reg <= 8'h00; msr_reg <= 8'h00;
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{read_data, irq_level, tx_valid, tx_byte, mc_valid, mc_lines, divisor_value};
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $error("result with no expectation waiting");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (got.rd != want.rd) $error("read_data exp %0h got %0h", want.rd, got.rd);
            if (got.irq != want.irq) $error("irq_level exp %0b got %0b", want.irq, got.irq);
            if (got.txv != want.txv) $error("tx_valid exp %0b got %0b", want.txv, got.txv);
            if (got.txb != want.txb) $error("tx_byte exp %0h got %0h", want.txb, got.txb);
            if (got.mcv != want.mcv) $error("mc_valid exp %0b got %0b", want.mcv, got.mcv);
            if (got.mcl != want.mcl) $error("mc_lines exp %0h got %0h", want.mcl, got.mcl);
            if (got.div != want.div)
              $error("divisor_value exp %0h got %0h", want.div, got.div);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_access(req_type, reg_offset, write_data,
                                                  line_byte, modem_lines));
    end
  end
endmodule

// ===== tb/sv/tb_uart_register_block_top.sv =====
// Testbench top for the UART register block: stimulus, reset and verdict.
module tb_uart_register_block_top;
  import urb_pkg::*;

  logic clk, rst, in_valid, in_stall, out_valid, out_stall;
  logic [2:0] req_type, reg_offset;
  logic [7:0] write_data, line_byte, read_data, tx_byte;
  logic [3:0] modem_lines, mc_lines;
  logic irq_level, tx_valid, mc_valid;
  logic [15:0] divisor_value;
  logic calm;
  int fail_count, pending_count, result_count, item_count;

  uart_register_block_top uut (.*);
  uart_register_block_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // random receiver stall bursts, quiet at the end
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // present one item and hold it until accepted
  task automatic send_access(logic [2:0] kind, logic [2:0] off, logic [7:0] wv,
                             logic [7:0] lb, logic [3:0] ml);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    reg_offset <= off;
    write_data <= wv;
    line_byte <= lb;
    modem_lines <= ml;
    do @(posedge clk); while (in_stall);
    item_count++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] off, logic [7:0] v);
    send_access(REQ_WRITE, off, v, 8'($urandom), 4'($urandom));
  endtask

  task automatic read_reg(logic [2:0] off);
    send_access(REQ_READ, off, 8'($urandom), 8'($urandom), 4'($urandom));
  endtask

  initial begin
    int pick;
    calm = 1'b0;
    item_count = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_WRITE;
    reg_offset = OFF_DATA;
    write_data = 8'h00;
    line_byte = 8'h00;
    modem_lines = 4'h0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: divisor latches, IER, rings, loopback, modem, odd kinds
    write_reg(OFF_LCR, 8'h80);
    write_reg(OFF_DATA, 8'hff);
    write_reg(OFF_IER, 8'h00);
    read_reg(OFF_DATA);
    read_reg(OFF_IER);
    write_reg(OFF_LCR, 8'h03);
    write_reg(OFF_IER, 8'h0f);
    read_reg(OFF_DATA);
    read_reg(OFF_IIR);
    write_reg(OFF_DATA, 8'h00);
    read_reg(OFF_IIR);
    send_access(REQ_PULL, OFF_DATA, 8'h00, 8'h00, 4'h0);
    send_access(REQ_PULL, OFF_DATA, 8'h00, 8'h00, 4'h0);
    send_access(REQ_RXB, OFF_DATA, 8'h00, 8'hff, 4'h0);
    read_reg(OFF_IIR);
    read_reg(OFF_LSR);
    read_reg(OFF_DATA);
    send_access(REQ_MODEM, OFF_DATA, 8'h00, 8'h00, 4'hf);
    send_access(REQ_MODEM, OFF_DATA, 8'h00, 8'h00, 4'hf);
    read_reg(OFF_MSR);
    write_reg(OFF_MCR, 8'hff);
    write_reg(OFF_DATA, 8'h5a);
    read_reg(OFF_MCR);
    write_reg(OFF_SCR, 8'ha5);
    send_access(3'd7, OFF_SCR, 8'hff, 8'hff, 4'hf);

    // fill both rings past full, then drain
    write_reg(OFF_MCR, 8'h00);
    repeat (66) send_access(REQ_RXB, OFF_DATA, 8'h00, 8'($urandom), 4'h0);
    repeat (66) write_reg(OFF_DATA, 8'($urandom));
    read_reg(OFF_LSR);
    repeat (66) read_reg(OFF_DATA);
    repeat (66) send_access(REQ_PULL, OFF_DATA, 8'h00, 8'h00, 4'h0);

    // random mix weighted toward meaningful traffic
    for (int n = 0; n < 100; n++) begin
      if (n == 85) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 30) send_access(REQ_WRITE, 3'($urandom), 8'($urandom), 8'($urandom),
                                 4'($urandom));
      else if (pick < 55) send_access(REQ_READ, 3'($urandom), 8'($urandom), 8'($urandom),
                                      4'($urandom));
      else if (pick < 70) send_access(REQ_RXB, 3'($urandom), 8'($urandom), 8'($urandom),
                                      4'($urandom));
      else if (pick < 85) send_access(REQ_PULL, 3'($urandom), 8'($urandom), 8'($urandom),
                                      4'($urandom));
      else if (pick < 96) send_access(REQ_MODEM, 3'($urandom), 8'($urandom), 8'($urandom),
                                      4'($urandom));
      else send_access(3'($urandom_range(5, 7)), 3'($urandom), 8'($urandom), 8'($urandom),
                       4'($urandom));
      // keep DLAB mostly clear so data traffic reaches the rings
      if ($urandom_range(0, 9) == 0) write_reg(OFF_LCR, 8'($urandom) & 8'h7f);
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Run covered %0d items and %0d results: register access, rings, loopback,",
             item_count, result_count);
    $display("divisor latches, interrupt ranking and modem deltas.");
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
